[src/swn_pkg.sv]
package swn_pkg;

  // Dimensions held in hardware and how many of them take part (innermost first)
  localparam int NUM_DIMS  = 4;
  localparam int MAX_DIMS  = 4;
  localparam int ADDR_BITS = 32;

  localparam int CNT_W    = 16;
  localparam int STRIDE_W = 32;
  localparam int SETUP_W  = CNT_W + STRIDE_W;
  localparam int PROD_W   = CNT_W + STRIDE_W;
  // four products plus a 32-bit base stay below 2^(PROD_W + clog2(NUM_DIMS) + 1)
  localparam int SUM_W    = PROD_W + $clog2(NUM_DIMS) + 1;
  localparam int OUT_ADDR_W = 32;
  localparam int LIN_W    = 64;
  localparam int BASE_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [SETUP_W-1:0] DIM_RESET_OUTER = SETUP_W'(64'h1_0000_0000);
  localparam logic [SETUP_W-1:0] DIM_RESET_INNER = SETUP_W'(64'h1_0000_0001);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM0 = 3'd0,
    REG_DIM1 = 3'd1,
    REG_DIM2 = 3'd2,
    REG_DIM3 = 3'd3,
    REG_BASE = 3'd4
  } cfg_reg_t;

  // Handed from a cell to its outer neighbor
  typedef struct packed {
    logic carry;   // increment request moving outward
    logic at_end;  // every cell so far sits at its last position
  } swn_link_t;

endpackage

[src/swn_cell.sv]
module swn_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [swn_pkg::SETUP_W-1:0]   setup,
  input  logic                          active,
  input  logic                          restart,
  input  logic                          adv,
  input  swn_pkg::swn_link_t            link_i,
  output swn_pkg::swn_link_t            link_o,
  output logic [swn_pkg::PROD_W-1:0]    prod_r
);
  import swn_pkg::*;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_cur, ext;
  logic [CNT_W:0]      ext_eff, cnt_inc;
  logic [STRIDE_W-1:0] stride;
  logic                wrap, at_end;
  logic [PROD_W-1:0]   prod_nxt;

  assign ext     = setup[SETUP_W-1:STRIDE_W];
  assign stride  = setup[STRIDE_W-1:0];
  assign ext_eff = (ext == '0) ? (CNT_W+1)'(1) : {1'b0, ext};
  assign cnt_cur = restart ? '0 : cnt_r;
  assign cnt_inc = {1'b0, cnt_cur} + (CNT_W+1)'(1);
  // wrap also covers a count left above a shrunken extent
  assign wrap    = cnt_inc >= ext_eff;
  assign at_end  = !active || wrap;

  assign link_o.carry  = link_i.carry && at_end;
  assign link_o.at_end = link_i.at_end && at_end;

  always_comb begin
    cnt_nxt = cnt_cur;
    if (!active) begin
      cnt_nxt = '0;
    end else if (link_i.carry) begin
      cnt_nxt = wrap ? '0 : cnt_inc[CNT_W-1:0];
    end
  end

  assign prod_nxt = active ? (PROD_W'(cnt_cur) * PROD_W'(stride)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[src/strided_nd_address_walker.sv]
// Strided N-dimensional address walker.
// The product registers and then the output register lie between an accepted input beat and its result beat.
// Throughput: one beat per cycle while out_stall is low; the carry chain through the cells and one
//   16x32 product per cell sit in the first stage, the address sum in the second.
// Reset (rst_n low, synchronous): counters, element count and valid flags clear;
//   registers return to extent 1 / stride 0 (innermost stride 1), base 0.
module strided_nd_address_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swn_pkg::SETUP_W-1:0]       cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [swn_pkg::OUT_ADDR_W-1:0]    out_strided_address,
  output logic [swn_pkg::LIN_W-1:0]         out_linear_index,
  output logic                              out_last,
  output logic                              out_overflow
);
  import swn_pkg::*;

  localparam logic [SUM_W-1:0] ADDR_MASK = (SUM_W'(1) << ADDR_BITS) - SUM_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the walker is drained; the block
  // itself does not enforce this, and the port is always ready.
  // ---------------------------------------------------------------------------
  logic [SETUP_W-1:0] setup_r [NUM_DIMS];
  logic [BASE_W-1:0]  base_r;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r[0] <= DIM_RESET_OUTER;
      setup_r[1] <= DIM_RESET_OUTER;
      setup_r[2] <= DIM_RESET_OUTER;
      setup_r[3] <= DIM_RESET_INNER;
      base_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM0: setup_r[0] <= cfg_data;
        REG_DIM1: setup_r[1] <= cfg_data;
        REG_DIM2: setup_r[2] <= cfg_data;
        REG_DIM3: setup_r[3] <= cfg_data;
        REG_BASE: base_r     <= cfg_data[BASE_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stage 1 holds products, stage 2 is the output register.
  // Each stage loads when it is empty or its contents move on this cycle.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, out_valid_r;
  logic en1, en2, acc;

  assign en2      = !out_valid_r || !out_stall;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;
  assign acc      = in_valid && en1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_valid;
      end
      if (en2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row of counter cells. The carry and the end flag start at the innermost
  // dimension and move outward; the link leaving the outermost cell tells
  // whether this beat is the final element of the walk.
  // ---------------------------------------------------------------------------
  swn_link_t          link [NUM_DIMS+1];
  logic [PROD_W-1:0]  prod_r [NUM_DIMS];

  assign link[NUM_DIMS].carry  = 1'b1;
  assign link[NUM_DIMS].at_end = 1'b1;

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
    swn_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .setup   (setup_r[d]),
      .active  ((d >= NUM_DIMS - MAX_DIMS) ? 1'b1 : 1'b0),
      .restart (in_restart),
      .adv     (acc),
      .link_i  (link[d+1]),
      .link_o  (link[d]),
      .prod_r  (prod_r[d])
    );
  end

  logic last_now;
  assign last_now = link[0].at_end;

  // Element count: restart clears it before use, the final element wraps it.
  logic [LIN_W-1:0] ec_r, ec_cur, ec_nxt;
  assign ec_cur = in_restart ? '0 : ec_r;
  assign ec_nxt = last_now ? '0 : ec_cur + LIN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r <= '0;
    end else if (acc) begin
      ec_r <= ec_nxt;
    end
  end

  // stage 1 side data travelling with the products
  logic [LIN_W-1:0] s1_lin_r;
  logic             s1_last_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_lin_r  <= ec_cur;
      s1_last_r <= last_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: add the base and all products, then wrap to the address width.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = SUM_W'(base_r);
    for (int d = 0; d < NUM_DIMS; d++) begin
      sum = sum + SUM_W'(prod_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      out_strided_address <= OUT_ADDR_W'(sum & ADDR_MASK);
      out_overflow        <= |(sum >> ADDR_BITS);
      out_linear_index    <= s1_lin_r;
      out_last            <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_now) |=> (ec_r == '0))
    else $error("element count not cleared after final element");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !last_now) |=> (ec_r == $past(ec_cur) + LIN_W'(1)))
    else $error("element count did not advance by one");

  a_stage1_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && en2) |=> out_valid_r)
    else $error("stage 1 beat lost on its way to the output");

endmodule
